// File: rtl/assert_macros.svh
// Assertion macros used by the histogram top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define LHP_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define LHP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lhp_pkg.sv
// Shared types, codes and constants of the latency histogram engine.
package lhp_pkg;

    // Default geometry of the histogram.
    localparam int unsigned NUM_BUCKETS_DEF  = 128;
    localparam int unsigned BUCKET_WIDTH_DEF = 5;

    // Field widths.
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned PCT_W    = 7;
    localparam int unsigned RESULT_W = 10;
    localparam int unsigned PROD_W   = WORD_W + PCT_W;

    // Percent scale and its saturation value.
    localparam int unsigned SCALE = 100;
    localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(SCALE);

    // Command codes.
    typedef logic [FUNC_W-1:0] func_t;
    localparam func_t FUNC_RECORD = 2'd0;
    localparam func_t FUNC_CLEAR  = 2'd1;
    localparam func_t FUNC_QUERY  = 2'd2;

    // Command transaction.
    typedef struct packed {
        func_t               func;
        logic [WORD_W-1:0]   sample_value;
        logic [PCT_W-1:0]    percent;
        logic [WORD_W-1:0]   total_count;
    } lhp_cmd_t;

    // Result transaction.
    typedef struct packed {
        logic [RESULT_W-1:0] result_value;
        logic [WORD_W-1:0]   overflow_count;
    } lhp_res_t;

    // Control from the sequencer to the percentile scan unit.
    typedef struct packed {
        logic start;
        logic run;
        logic dvalid;
        logic dlast;
    } lhp_scan_ctrl_t;

endpackage

// File: rtl/lhp_mem.sv
// Bucket counter memory: one write port and one registered read port.
module lhp_mem #(
    parameter int unsigned DEPTH = lhp_pkg::NUM_BUCKETS_DEF,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [lhp_pkg::WORD_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [lhp_pkg::WORD_W-1:0] rdata
);
    import lhp_pkg::*;

    logic [WORD_W-1:0] mem_array [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    // Synchronous write and read; the read data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/lhp_bin.sv
// Bucket index unit: divides a sample by the bucket width through a reciprocal product.
module lhp_bin #(
    parameter int unsigned NUM_BUCKETS  = lhp_pkg::NUM_BUCKETS_DEF,
    parameter int unsigned BUCKET_WIDTH = lhp_pkg::BUCKET_WIDTH_DEF,
    localparam int unsigned IDX_W = $clog2(NUM_BUCKETS)
) (
    input  logic                       clk,
    input  logic                       load,
    input  logic [lhp_pkg::WORD_W-1:0] sample,
    output logic [IDX_W-1:0]           idx,
    output logic                       in_range
);
    import lhp_pkg::*;

    // Samples below LIMIT land in a bucket; they fit in VAL_W bits.
    localparam int unsigned LIMIT   = NUM_BUCKETS * BUCKET_WIDTH;
    localparam int unsigned VAL_W   = $clog2(LIMIT);
    // With this shift the rounded-up reciprocal gives the exact quotient for every VAL_W-bit value.
    localparam int unsigned SHIFT   = VAL_W + $clog2(BUCKET_WIDTH);
    localparam int unsigned RECIP_W = SHIFT + 1;
    localparam int unsigned MUL_W   = VAL_W + RECIP_W;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + BUCKET_WIDTH - 1) / BUCKET_WIDTH;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_L[RECIP_W-1:0];

    logic [MUL_W-1:0] prod;
    logic [IDX_W-1:0] idx_reg;
    logic             in_range_reg;

    // Quotient by multiplication with the reciprocal.
    assign prod = MUL_W'(sample[VAL_W-1:0]) * MUL_W'(RECIP);

    // The index and the range flag are registered after the multiplier.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            idx_reg      <= prod[SHIFT +: IDX_W];
            in_range_reg <= (sample < WORD_W'(LIMIT));
        end
    end

    assign idx      = idx_reg;
    assign in_range = in_range_reg;

endmodule

// File: rtl/lhp_scan.sv
// Percentile scan unit: running scaled sum over the buckets and the target compare.
module lhp_scan #(
    parameter int unsigned NUM_BUCKETS  = lhp_pkg::NUM_BUCKETS_DEF,
    parameter int unsigned BUCKET_WIDTH = lhp_pkg::BUCKET_WIDTH_DEF,
    localparam int unsigned MID_W = $clog2(NUM_BUCKETS * BUCKET_WIDTH + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lhp_pkg::lhp_scan_ctrl_t    ctrl,
    input  logic [lhp_pkg::WORD_W-1:0] rdata,
    input  logic [lhp_pkg::PROD_W-1:0] target,
    output logic                       done,
    output logic [MID_W-1:0]           result
);
    import lhp_pkg::*;

    localparam int unsigned IDX_W    = $clog2(NUM_BUCKETS);
    // The sum is kept scaled by the percent base, so it never wraps.
    localparam int unsigned ACC_W    = PROD_W + IDX_W;
    localparam int unsigned SCALED_W = PROD_W;
    localparam int unsigned HALF     = BUCKET_WIDTH / 2;
    localparam int unsigned LIMIT    = NUM_BUCKETS * BUCKET_WIDTH;

    logic                a_valid_reg;
    logic                a_last_reg;
    logic [SCALED_W-1:0] a_scaled_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [ACC_W-1:0]    acc_sum;
    logic [MID_W-1:0]    mid_reg;
    logic [MID_W-1:0]    result_reg;
    logic                done_reg;
    logic                step;
    logic                hit;

    // The target floor(P / 100) is reached when 100 * sum + 99 >= P, so the
    // accumulator starts at 99 and adds each count times 100.
    assign step    = ctrl.run && a_valid_reg && !done_reg;
    assign acc_sum = acc_reg + ACC_W'(a_scaled_reg);
    assign hit     = (acc_sum >= ACC_W'(target));

    // Control flags of the two stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= ctrl.run && ctrl.dvalid && !ctrl.start;
            if (ctrl.start)
            begin
                done_reg <= 1'b0;
            end
            else if (step && (hit || a_last_reg))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // Stage A scales the count read from memory; stage B accumulates and compares.
    always_ff @(posedge clk)
    begin
        a_scaled_reg <= SCALED_W'(rdata) * SCALED_W'(SCALE);
        a_last_reg   <= ctrl.dlast;
        if (ctrl.start)
        begin
            acc_reg <= ACC_W'(SCALE - 1);
            mid_reg <= MID_W'(HALF);
        end
        else if (step)
        begin
            acc_reg <= acc_sum;
            mid_reg <= mid_reg + MID_W'(BUCKET_WIDTH);
            if (hit)
            begin
                result_reg <= mid_reg;
            end
            else if (a_last_reg)
            begin
                result_reg <= MID_W'(LIMIT);
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: rtl/latency_histogram_percentile_top.sv
// Latency histogram engine: sequencer, overflow counter and result register.
// Record: index, read, write back and result, with no write back on overflow; clear walks every bucket.
// Query: a walk over the buckets that reads one bucket a cycle until the target is met;
// a query with zero total or an unused code goes straight to the result. One command at a time.
// Reset clears the overflow counter and starts a clearing pass over the whole
// bucket memory, one entry a cycle, with cmd_ready low.
`include "assert_macros.svh"

module latency_histogram_percentile_top #(
    parameter int unsigned NUM_BUCKETS  = lhp_pkg::NUM_BUCKETS_DEF,
    parameter int unsigned BUCKET_WIDTH = lhp_pkg::BUCKET_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  lhp_pkg::lhp_cmd_t cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output lhp_pkg::lhp_res_t res
);
    import lhp_pkg::*;

    localparam int unsigned IDX_W = $clog2(NUM_BUCKETS);
    localparam int unsigned CNT_W = $clog2(NUM_BUCKETS + 1);
    localparam int unsigned MID_W = $clog2(NUM_BUCKETS * BUCKET_WIDTH + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_BUCKETS - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(NUM_BUCKETS);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CLEAR  = 6'b000010,
        S_REC_RD = 6'b000100,
        S_REC_WR = 6'b001000,
        S_SCAN   = 6'b010000,
        S_RESP   = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]      rd_cnt_reg, rd_cnt_next;
    logic                  pending_reg, pending_next;
    logic [WORD_W-1:0]     overflow_reg, overflow_next;
    logic [RESULT_W-1:0]   res_value_reg, res_value_next;
    logic [PROD_W-1:0]     target_reg, target_next;
    logic                  dvalid_reg, dvalid_next;
    logic                  dlast_reg, dlast_next;
    logic                  out_valid_reg, out_valid_next;
    lhp_res_t              out_reg, out_next;

    logic                  cmd_fire;
    logic [PCT_W-1:0]      pct_sat;
    logic                  issue;
    logic [IDX_W-1:0]      bin_idx;
    logic                  bin_in_range;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [WORD_W-1:0]     mem_wdata;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;
    logic [WORD_W-1:0]     mem_rdata;
    lhp_scan_ctrl_t        scan_ctrl;
    logic                  scan_done;
    logic [MID_W-1:0]      scan_result;

    assign cmd_ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign pct_sat   = (cmd.percent > PCT_MAX) ? PCT_MAX : cmd.percent;
    assign issue     = (state_reg == S_SCAN) && (rd_cnt_reg < CNT_END);

    // Bucket index of the incoming sample.
    lhp_bin #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .BUCKET_WIDTH (BUCKET_WIDTH)
    ) u_bin (
        .clk      (clk),
        .load     (cmd_fire),
        .sample   (cmd.sample_value),
        .idx      (bin_idx),
        .in_range (bin_in_range)
    );

    // Memory port selection: the clearing pass and the record write back share the write port.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = bin_idx;
        mem_wdata = mem_rdata + WORD_W'(1);
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg[IDX_W-1:0];
            mem_wdata = '0;
        end
        else if (state_reg == S_REC_WR)
        begin
            mem_we = 1'b1;
        end
        mem_re    = issue || ((state_reg == S_REC_RD) && bin_in_range);
        mem_raddr = (state_reg == S_REC_RD) ? bin_idx : rd_cnt_reg[IDX_W-1:0];
    end

    lhp_mem #(
        .DEPTH (NUM_BUCKETS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Percentile walk over the read data stream.
    assign scan_ctrl.start  = cmd_fire && (cmd.func == FUNC_QUERY);
    assign scan_ctrl.run    = (state_reg == S_SCAN);
    assign scan_ctrl.dvalid = dvalid_reg;
    assign scan_ctrl.dlast  = dlast_reg;

    lhp_scan #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .BUCKET_WIDTH (BUCKET_WIDTH)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (scan_ctrl),
        .rdata  (mem_rdata),
        .target (target_reg),
        .done   (scan_done),
        .result (scan_result)
    );

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        rd_cnt_next    = rd_cnt_reg;
        pending_next   = pending_reg;
        overflow_next  = overflow_reg;
        res_value_next = res_value_reg;
        target_next    = target_reg;
        dvalid_next    = issue;
        dlast_next     = (rd_cnt_reg == CNT_LAST);
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.func)
                        FUNC_RECORD:
                        begin
                            state_next = S_REC_RD;
                        end
                        FUNC_CLEAR:
                        begin
                            overflow_next = '0;
                            clr_cnt_next  = '0;
                            pending_next  = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        FUNC_QUERY:
                        begin
                            target_next = PROD_W'(cmd.total_count) * PROD_W'(pct_sat);
                            rd_cnt_next = '0;
                            if (cmd.total_count == '0)
                            begin
                                res_value_next = '0;
                                state_next     = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_value_next = '0;
                            state_next     = S_RESP;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                if (clr_cnt_reg == CNT_LAST)
                begin
                    res_value_next = '0;
                    pending_next   = 1'b0;
                    state_next     = pending_reg ? S_RESP : S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + CNT_W'(1);
                end
            end
            S_REC_RD:
            begin
                res_value_next = '0;
                if (bin_in_range)
                begin
                    state_next = S_REC_WR;
                end
                else
                begin
                    overflow_next = overflow_reg + WORD_W'(1);
                    state_next    = S_RESP;
                end
            end
            S_REC_WR:
            begin
                state_next = S_RESP;
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                if (scan_done)
                begin
                    res_value_next = RESULT_W'(scan_result);
                    state_next     = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_valid_next          = 1'b1;
                    out_next.result_value   = res_value_reg;
                    out_next.overflow_count = overflow_reg;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers; reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            rd_cnt_reg    <= '0;
            pending_reg   <= 1'b0;
            overflow_reg  <= '0;
            dvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rd_cnt_reg    <= rd_cnt_next;
            pending_reg   <= pending_next;
            overflow_reg  <= overflow_next;
            dvalid_reg    <= dvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        res_value_reg <= res_value_next;
        target_reg    <= target_next;
        dlast_reg     <= dlast_next;
        out_reg       <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Checks on the sequencer.
    `LHP_ASSERT_IMPL(a_wr_in_range, state_reg == S_REC_WR, bin_in_range, "write out of range")
    `LHP_ASSERT_IMPL(a_res_from_resp, $rose(res_valid), $past(state_reg == S_RESP), "stray result")
    `LHP_ASSERT_IMPL(a_scan_bound, state_reg == S_SCAN, rd_cnt_reg <= CNT_END, "walk overran")
    `LHP_ASSERT_NEXT(a_clear_ovf, cmd_fire && cmd.func == FUNC_CLEAR, overflow_reg == '0, "no clear")

endmodule

// File: dv/latency_histogram_percentile_top_test.sv
// Self-checking testbench for the latency histogram engine with percentile query.
`timescale 1ns / 1ps

module latency_histogram_percentile_top_test;

    import lhp_pkg::*;

    localparam int unsigned NBK = NUM_BUCKETS_DEF;
    localparam int unsigned BW  = BUCKET_WIDTH_DEF;
    // Span of all buckets; a query that no bucket satisfies returns this value.
    localparam int unsigned SPAN = NBK * BW;
    // The one command code that the block leaves without meaning.
    localparam func_t FUNC_UNUSED = 2'd3;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_ready;
    lhp_cmd_t cmd       = '0;
    logic     res_valid;
    logic     res_ready = 1'b0;
    lhp_res_t res;

    // Shadow copy of the histogram that the block should hold.
    logic [WORD_W-1:0] bucket_tally [NBK];
    logic [WORD_W-1:0] overflow_tally;
    int unsigned       samples_held;

    // Results still owed by the block, oldest first.
    lhp_res_t owed_results [$];

    bit          steady      = 1'b0;
    int unsigned error_count = 0;
    int unsigned n_record    = 0;
    int unsigned n_clear     = 0;
    int unsigned n_query     = 0;
    int unsigned n_unused    = 0;
    int unsigned n_checked   = 0;

    latency_histogram_percentile_top #(
        .NUM_BUCKETS  (NBK),
        .BUCKET_WIDTH (BW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Prints one line for a failure and counts it.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Walks the buckets cumulatively and returns the midpoint of the first one that
    // reaches total * percent / 100, with percent capped at 100; a zero total returns 0.
    function automatic logic [RESULT_W-1:0] scan_percentile(input logic [PCT_W-1:0] pct,
                                                            input logic [WORD_W-1:0] total);
        logic [PCT_W-1:0] pct_sat;
        logic [63:0]      target;
        logic [63:0]      running;
        if (total == '0)
            return '0;
        pct_sat = (pct > PCT_MAX) ? PCT_MAX : pct;
        target  = (64'(total) * 64'(pct_sat)) / 64'(SCALE);
        running = '0;
        for (int unsigned i = 0; i < NBK; i++)
        begin
            running += 64'(bucket_tally[i]);
            if (running >= target)
                return RESULT_W'(i * BW + BW / 2);
        end
        return RESULT_W'(SPAN);
    endfunction

    // Applies one command to the shadow histogram and returns the result it should give.
    function automatic lhp_res_t apply_command(input lhp_cmd_t c);
        lhp_res_t          r;
        logic [WORD_W-1:0] idx;
        r = '0;
        case (c.func)
            FUNC_RECORD:
            begin
                idx = c.sample_value / WORD_W'(BW);
                if (idx >= WORD_W'(NBK))
                    overflow_tally = overflow_tally + 1'b1;
                else
                    bucket_tally[idx] = bucket_tally[idx] + 1'b1;
                samples_held++;
                n_record++;
            end
            FUNC_CLEAR:
            begin
                foreach (bucket_tally[i])
                    bucket_tally[i] = '0;
                overflow_tally = '0;
                samples_held   = 0;
                n_clear++;
            end
            FUNC_QUERY:
            begin
                r.result_value = scan_percentile(c.percent, c.total_count);
                n_query++;
            end
            default:
                n_unused++;
        endcase
        r.overflow_count = overflow_tally;
        return r;
    endfunction

    // Drives one command transaction and records the result it should produce.
    task automatic send_cmd(input lhp_cmd_t c);
        while (!steady && $urandom_range(0, 99) < 9)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        owed_results.insert(owed_results.size(), apply_command(c));
        @(negedge clk);
    endtask

    // Lowers valid and waits until every owed result has arrived.
    task automatic wait_for_drain();
        cmd_valid <= 1'b0;
        @(negedge clk);
        while (owed_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic lhp_cmd_t make_cmd(input func_t f, input logic [WORD_W-1:0] sample,
                                          input logic [PCT_W-1:0] pct,
                                          input logic [WORD_W-1:0] total);
        lhp_cmd_t c;
        c.func         = f;
        c.sample_value = sample;
        c.percent      = pct;
        c.total_count  = total;
        return c;
    endfunction

    // Builds a random command, weighted towards records and towards queries whose total
    // matches what the histogram holds, so that the scan stops inside the buckets.
    function automatic lhp_cmd_t random_command();
        lhp_cmd_t    c;
        int unsigned pick;
        c.func         = FUNC_RECORD;
        c.sample_value = $urandom();
        c.percent      = PCT_W'($urandom_range(0, 127));
        c.total_count  = $urandom();
        pick           = $urandom_range(0, 99);
        if (pick < 66)
        begin
            case ($urandom_range(0, 7))
                0:       c.sample_value = $urandom_range(0, 4 * BW);
                1:       c.sample_value = $urandom();
                default: c.sample_value = $urandom_range(0, SPAN + 20);
            endcase
        end
        else if (pick < 74)
        begin
            // A cluster of samples in a few buckets gives the scan a sharp step.
            c.sample_value = $urandom_range(100, 120);
        end
        else if (pick < 95)
        begin
            c.func = FUNC_QUERY;
            if ($urandom_range(0, 9) != 0)
                c.percent = PCT_W'($urandom_range(0, 100));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: c.total_count = samples_held;
                5, 6:          c.total_count = $urandom_range(0, samples_held + 3);
                7:             c.total_count = samples_held + $urandom_range(1, 5);
                8:             c.total_count = $urandom();
                default:       c.total_count = '0;
            endcase
        end
        else if (pick < 98)
            c.func = FUNC_UNUSED;
        else
            c.func = FUNC_CLEAR;
        return c;
    endfunction

    // Corner cases: bucket boundaries, overflow, zero total, zero and saturated percent,
    // the widest product, the unused code and queries on an empty store.
    task automatic test_directed();
        send_cmd(make_cmd(FUNC_QUERY,  '0,           7'd50,  32'd5));
        send_cmd(make_cmd(FUNC_QUERY,  '0,           7'd100, '0));
        send_cmd(make_cmd(FUNC_QUERY,  '1,           7'd0,   32'd7));
        send_cmd(make_cmd(FUNC_RECORD, '0,           '1,     '1));
        send_cmd(make_cmd(FUNC_RECORD, BW - 1,       '0,     '0));
        send_cmd(make_cmd(FUNC_RECORD, BW,           '0,     '0));
        send_cmd(make_cmd(FUNC_RECORD, SPAN - 1,     '0,     '0));
        send_cmd(make_cmd(FUNC_RECORD, SPAN,         '0,     '0));
        send_cmd(make_cmd(FUNC_RECORD, '1,           '0,     '0));
        send_cmd(make_cmd(FUNC_RECORD, 32'hAAAAAAAA, 7'h55,  32'h55555555));
        send_cmd(make_cmd(FUNC_RECORD, 32'h55555555, 7'h2A,  32'hAAAAAAAA));
        send_cmd(make_cmd(FUNC_UNUSED, '1,           '1,     '1));
        send_cmd(make_cmd(FUNC_QUERY,  '0,           7'd100, 32'd4));
        send_cmd(make_cmd(FUNC_QUERY,  '0,           7'd127, 32'd4));
        send_cmd(make_cmd(FUNC_QUERY,  '0,           7'd101, 32'd3));
        send_cmd(make_cmd(FUNC_QUERY,  '0,           7'd50,  32'd4));
        send_cmd(make_cmd(FUNC_QUERY,  '1,           7'd100, '1));
        send_cmd(make_cmd(FUNC_QUERY,  '0,           7'd99,  '1));
        send_cmd(make_cmd(FUNC_CLEAR,  '1,           '1,     '1));
        send_cmd(make_cmd(FUNC_QUERY,  '0,           7'd100, 32'd1));
        send_cmd(make_cmd(FUNC_RECORD, '0,           '0,     '0));
        send_cmd(make_cmd(FUNC_QUERY,  '0,           7'd1,   32'd100));
        send_cmd(make_cmd(FUNC_QUERY,  '0,           7'd0,   '1));
    endtask

    // Random mix of commands with idling on both sides.
    task automatic test_random_mix(input int unsigned count);
        for (int unsigned n = 0; n < count; n++)
            send_cmd(random_command());
    endtask

    // Random mix with neither side idling.
    task automatic test_back_to_back(input int unsigned count);
        steady = 1'b1;
        for (int unsigned n = 0; n < count; n++)
            send_cmd(random_command());
        steady = 1'b0;
    endtask

    // A burst of records, a full drain, and then queries against the settled store.
    task automatic test_drain_pause();
        for (int unsigned n = 0; n < 30; n++)
            send_cmd(make_cmd(FUNC_RECORD, $urandom_range(0, SPAN + 40), '0, '0));
        wait_for_drain();
        for (int unsigned n = 0; n < 8; n++)
            send_cmd(make_cmd(FUNC_QUERY, '0, PCT_W'($urandom_range(0, 100)), samples_held));
    endtask

    // Result ready stalls at random except during the steady stretch.
    always @(negedge clk)
        res_ready <= steady || ($urandom_range(0, 99) >= 9);

    // Compares each result transaction with the oldest one owed.
    always @(posedge clk)
    begin
        lhp_res_t exp_res;
        if (rst_n && res_valid && res_ready)
        begin
            if (owed_results.size() == 0)
                report_mismatch($sformatf("result with none owed: value %0d overflow %0d",
                                          res.result_value, res.overflow_count));
            else
            begin
                exp_res = owed_results.pop_front();
                n_checked++;
                if (res.result_value !== exp_res.result_value)
                    report_mismatch($sformatf("result_value got %0d expected %0d",
                                              res.result_value, exp_res.result_value));
                if (res.overflow_count !== exp_res.overflow_count)
                    report_mismatch($sformatf("overflow_count got %0d expected %0d",
                                              res.overflow_count, exp_res.overflow_count));
            end
        end
    end

    // Main sequence.
    initial
    begin
        foreach (bucket_tally[i])
            bucket_tally[i] = '0;
        overflow_tally = '0;
        samples_held   = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_mix(600);
        test_drain_pause();
        test_back_to_back(250);
        test_random_mix(500);
        wait_for_drain();
        repeat (NBK + 10) @(posedge clk);
        $display("Covered %0d records, %0d clears, %0d queries and %0d unused codes;",
                 n_record, n_clear, n_query, n_unused);
        $display("%0d results compared, %0d failures.", n_checked, error_count);
        if (error_count == 0)
            $display("** latency_histogram_percentile_top: PASSED **");
        else
            $display("** latency_histogram_percentile_top: FAILED **");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #10ms;
        $display("Timed out with %0d results still owed.", owed_results.size());
        $display("** latency_histogram_percentile_top: FAILED **");
        $finish;
    end

endmodule
